// ===== rtl/core/tsmm_pkg.sv =====
package tsmm_pkg;

  localparam logic [15:0] SatMax = 16'h7FFF;
  localparam logic [15:0] OneQ12 = 16'd4096;

  // Configuration register indexes.
  localparam logic [1:0] RegLtrGain    = 2'd0;
  localparam logic [1:0] RegSlideLimit = 2'd1;
  localparam logic [1:0] RegInvPeriod  = 2'd2;

  // Sequencer states. Each product state waits for the product started on entry.
  typedef enum logic [3:0] {
    StIdle,
    StMulAy,
    StMulAyK,
    StMulAx,
    StMulLtr,
    StSqAx,
    StSqAy,
    StSumSq,
    StSqrt,
    StDone
  } state_e;

  // Control from the sequencer to the serial multiplier.
  typedef struct packed {
    logic        load;
    logic [31:0] mcand;
    logic [15:0] mplier;
  } mul_ctrl_t;

endpackage

// ===== rtl/core/tipover_slide_margin_monitor.sv =====
// Tip-over and slide margin monitor. Each speed/curvature beat yields one
// result beat with the tip margin (Q4.12), the slide margin (Q8.8), their
// running minima over the current run and a valid flag that is low on the
// first sample of a run. A beat that starts a run is answered in the next
// cycle. Any other beat runs through accept, multiplier start, six products
// on one bit-serial multiplier, a 16-step square root that retires one result
// bit per cycle and hand-off to the output register. One beat is processed at
// a time; the input stalls while a beat is in work and while the output
// register holds a result that is not being taken in the same cycle.
module tipover_slide_margin_monitor
  import tsmm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] speed_i,
  input  logic signed [15:0] curvature_i,
  input  logic        start_req_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] tip_margin_o,
  output logic signed [15:0] slide_margin_o,
  output logic signed [15:0] min_tip_margin_o,
  output logic signed [15:0] min_slide_margin_o,
  output logic        metrics_valid_o,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers.
  logic [15:0] ltr_gain_q, inv_period_q;
  logic [14:0] slide_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ltr_gain_q    <= 16'd381;
      slide_limit_q <= 15'd1758;
      inv_period_q  <= 16'd640;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegLtrGain:    ltr_gain_q    <= cfg_wdata;
        RegSlideLimit: slide_limit_q <= cfg_wdata[14:0];
        RegInvPeriod:  inv_period_q  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_e st_q, st_d;
  logic [15:0] prev_q, spd_q, kmag_q, dv_q;
  logic [15:0] ay_q, ax_q;
  logic signed [15:0] tip_q, low_tip_q, low_slide_q;
  logic [31:0] ax_sq_q;
  logic [31:0] rad_q;
  logic [17:0] rem_q;
  logic [15:0] root_q;
  logic [4:0]  sq_cnt_q;
  logic        have_prev_q;
  logic        ovalid_q;
  logic signed [15:0] r_tip_q, r_slide_q, r_mtip_q, r_mslide_q;
  logic        r_mv_q;

  mul_ctrl_t   mul_ctrl;
  logic        mul_done;
  logic [47:0] mul_prod;

  tsmm_sermul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  logic accept, out_take, out_free, first_beat, ovalid_set;
  assign out_take   = out_valid && !out_stall;
  assign out_free   = !ovalid_q || out_take;
  assign in_stall   = (st_q != StIdle) || !out_free;
  assign accept     = in_valid && !in_stall;
  assign first_beat = start_req_i || !have_prev_q;
  assign ovalid_set = (accept && first_beat) || (st_q == StDone && out_free);

  // Rounded and saturated product views.
  logic [47:0] ay_rnd, ax_rnd, ltr_rnd;
  logic [15:0] ay_sat, ax_sat;
  logic signed [17:0] tip_wide;
  logic signed [15:0] tip_sat;
  assign ay_rnd  = (mul_prod + 48'h80000) >> 20;
  assign ax_rnd  = (mul_prod + 48'd8) >> 4;
  assign ltr_rnd = (mul_prod + 48'd128) >> 8;
  assign ay_sat  = (ay_rnd > 48'd32767) ? SatMax : ay_rnd[15:0];
  assign ax_sat  = (ax_rnd > 48'd32767) ? SatMax : ax_rnd[15:0];
  assign tip_wide = (ltr_rnd > 48'd40960) ? -18'sd36864
                  : 18'(signed'({1'b0, OneQ12})) - 18'(signed'({1'b0, ltr_rnd[16:0]}));
  assign tip_sat = (tip_wide < -18'sd32768) ? 16'sh8000 : tip_wide[15:0];

  // Square-root step: bring down two radicand bits and try the next root bit.
  logic [19:0] rem_sh;
  logic [20:0] sq_trial;
  assign rem_sh   = {rem_q, rad_q[31:30]};
  assign sq_trial = {1'b0, rem_sh} - {3'b0, root_q, 2'b01};

  logic signed [16:0] slide_wide;
  logic signed [15:0] r_slide_d;
  assign slide_wide = 17'(signed'({2'b0, slide_limit_q})) - 17'(signed'({1'b0, root_q}));
  assign r_slide_d  = (slide_wide < -17'sd32768) ? -16'sh8000 : slide_wide[15:0];

  // Sequencer: next state and multiplier commands.
  always_comb begin
    st_d = st_q;
    mul_ctrl = '0;
    unique case (st_q)
      StIdle: if (accept && !first_beat) st_d = StMulAy;
      StMulAy: begin
        mul_ctrl.load = 1'b1;
        mul_ctrl.mcand = {16'b0, spd_q};
        mul_ctrl.mplier = spd_q;
        st_d = StMulAyK;
      end
      StMulAyK: if (mul_done) begin
        mul_ctrl.load = 1'b1;
        mul_ctrl.mcand = mul_prod[31:0];
        mul_ctrl.mplier = kmag_q;
        st_d = StMulAx;
      end
      StMulAx: if (mul_done) begin
        mul_ctrl.load = 1'b1;
        mul_ctrl.mcand = {16'b0, dv_q};
        mul_ctrl.mplier = inv_period_q;
        st_d = StMulLtr;
      end
      StMulLtr: if (mul_done) begin
        mul_ctrl.load = 1'b1;
        mul_ctrl.mcand = {16'b0, ay_q};
        mul_ctrl.mplier = ltr_gain_q;
        st_d = StSqAx;
      end
      StSqAx: if (mul_done) begin
        mul_ctrl.load = 1'b1;
        mul_ctrl.mcand = {16'b0, ax_q};
        mul_ctrl.mplier = ax_q;
        st_d = StSqAy;
      end
      StSqAy: if (mul_done) begin
        mul_ctrl.load = 1'b1;
        mul_ctrl.mcand = {16'b0, ay_q};
        mul_ctrl.mplier = ay_q;
        st_d = StSumSq;
      end
      StSumSq: if (mul_done) st_d = StSqrt;
      StSqrt: if (sq_cnt_q == 5'd1) st_d = StDone;
      StDone: if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // Control state, run history, root step count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      low_tip_q   <= 16'sh7FFF;
      low_slide_q <= 16'sh7FFF;
      ovalid_q    <= 1'b0;
      sq_cnt_q    <= '0;
    end else begin
      st_q <= st_d;
      if (ovalid_set) ovalid_q <= 1'b1;
      else if (out_take) ovalid_q <= 1'b0;
      if (accept) begin
        prev_q      <= speed_i;
        have_prev_q <= 1'b1;
      end
      if (accept && first_beat) begin
        low_tip_q   <= 16'sh7FFF;
        low_slide_q <= 16'sh7FFF;
      end else if (st_q == StDone && out_free) begin
        if (tip_q < low_tip_q) low_tip_q <= tip_q;
        if (r_slide_d < low_slide_q) low_slide_q <= r_slide_d;
      end
      if (st_q == StSumSq && mul_done) sq_cnt_q <= 5'd16;
      else if (st_q == StSqrt) sq_cnt_q <= sq_cnt_q - 5'd1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      spd_q  <= speed_i;
      kmag_q <= curvature_i[15] ? 16'(17'h10000 - {1'b0, curvature_i}) : curvature_i;
      dv_q   <= (speed_i >= prev_q) ? speed_i - prev_q : prev_q - speed_i;
    end
    if (st_q == StMulAx && mul_done) ay_q <= ay_sat;
    if (st_q == StMulLtr && mul_done) ax_q <= ax_sat;
    if (st_q == StSqAx && mul_done) tip_q <= tip_sat;
    if (st_q == StSqAy && mul_done) ax_sq_q <= mul_prod[31:0];
  end

  // Square root of ax^2 + ay^2 (below 2^31), one root bit per cycle.
  always_ff @(posedge clk_i) begin
    if (st_q == StSumSq && mul_done) begin
      rad_q  <= ax_sq_q + mul_prod[31:0];
      rem_q  <= '0;
      root_q <= '0;
    end else if (st_q == StSqrt) begin
      rad_q <= {rad_q[29:0], 2'b00};
      if (!sq_trial[20]) begin
        rem_q  <= sq_trial[17:0];
        root_q <= {root_q[14:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[17:0];
        root_q <= {root_q[14:0], 1'b0};
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (accept && first_beat) begin
      r_tip_q    <= '0;
      r_slide_q  <= '0;
      r_mtip_q   <= 16'sh7FFF;
      r_mslide_q <= 16'sh7FFF;
      r_mv_q     <= 1'b0;
    end else if (st_q == StDone && out_free) begin
      r_tip_q    <= tip_q;
      r_slide_q  <= r_slide_d;
      r_mtip_q   <= (tip_q < low_tip_q) ? tip_q : low_tip_q;
      r_mslide_q <= (r_slide_d < low_slide_q) ? r_slide_d : low_slide_q;
      r_mv_q     <= 1'b1;
    end
  end

  assign out_valid          = ovalid_q;
  assign tip_margin_o       = r_tip_q;
  assign slide_margin_o     = r_slide_q;
  assign min_tip_margin_o   = r_mtip_q;
  assign min_slide_margin_o = r_mslide_q;
  assign metrics_valid_o    = r_mv_q;

  // The running tip minimum never exceeds its reset value; the slide minimum never exceeds the result.
  a_min_tip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (min_tip_margin_o <= 16'sh7FFF))
    else $error("min tip out of range");
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !metrics_valid_o) |-> (tip_margin_o == 16'sd0 && slide_margin_o == 16'sd0))
    else $error("first sample result not zero");
  a_min_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && metrics_valid_o) |-> (min_slide_margin_o <= slide_margin_o))
    else $error("slide minimum above result");

endmodule

// ===== rtl/core/tsmm_sermul.sv =====
// Bit-serial shift-add multiplier: 32-bit multiplicand by 16-bit multiplier,
// one multiplier bit per cycle.
module tsmm_sermul
  import tsmm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mul_ctrl_t   ctrl_i,
  output logic        done_o,
  output logic [47:0] prod_o
);

  logic [47:0] acc_q, acc_d;
  logic [15:0] mpl_q, mpl_d;
  logic [31:0] mcd_q, mcd_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] top;
  logic [47:0] step;

  // One step: add the multiplicand when the low multiplier bit is set, shift right.
  assign top  = {1'b0, acc_q[47:16]} + (mpl_q[0] ? {1'b0, mcd_q} : 33'd0);
  assign step = {top, acc_q[15:1]};

  always_comb begin
    acc_d = acc_q;
    mpl_d = mpl_q;
    mcd_d = mcd_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      acc_d = '0;
      mpl_d = ctrl_i.mplier;
      mcd_d = ctrl_i.mcand;
      cnt_d = 5'd16;
    end else if (cnt_q != 5'd0) begin
      acc_d = step;
      mpl_d = {1'b0, mpl_q[15:1]};
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mpl_q <= mpl_d;
    mcd_q <= mcd_d;
  end

  // The finished product is the last step, valid while done_o is high.
  assign done_o = (cnt_q == 5'd1);
  assign prod_o = step;

endmodule

// ===== tb/tb_tipover_slide_margin_monitor.sv =====
`timescale 1ns / 100ps

module tb_tipover_slide_margin_monitor;
  import tsmm_pkg::*;

  // An index that selects no register.
  localparam logic [1:0] RegNone = 2'd3;

  // Result beat as the block presents it.
  typedef struct packed {
    logic signed [15:0] tip;
    logic signed [15:0] slide;
    logic signed [15:0] min_tip;
    logic signed [15:0] min_slide;
    logic               metrics_ok;
  } margins_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] speed_i = '0;
  logic signed [15:0] curvature_i = '0;
  logic start_req_i = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] tip_margin_o, slide_margin_o, min_tip_margin_o, min_slide_margin_o;
  logic metrics_valid_o;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  tipover_slide_margin_monitor dut (.*);

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the registers and state of the block.
  logic [15:0] gain_q12 = 16'd381;
  logic [14:0] mu_g_q8 = 15'd1758;
  logic [15:0] rate_q4 = 16'd640;
  logic [15:0] last_speed = '0;
  logic        run_open = 1'b0;
  logic signed [15:0] run_min_tip = 16'sh7FFF;
  logic signed [15:0] run_min_slide = 16'sh7FFF;

  margins_t pending_margins[$];
  int errors = 0;
  bit rx_idle_en = 1'b1;
  bit tx_idle_en = 1'b1;
  int hold_rx = 0;
  int rx_gap = 0;

  function automatic logic signed [15:0] sat16(longint x);
    if (x > 32767) return 16'sh7FFF;
    if (x < -32768) return -16'sh8000;
    return x[15:0];
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r;
    r = 0;
    for (int b = 15; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) r |= 64'd1 << b;
    return r;
  endfunction

  // Compute the margins for one sample and advance the shadow state.
  function automatic margins_t predict_margins(logic [15:0] spd, logic signed [15:0] curv,
                                               logic first);
    margins_t m;
    longint unsigned kmag, ay, ax, dv, ltr;
    m = '0;
    if (first || !run_open) begin
      run_min_tip = 16'sh7FFF;
      run_min_slide = 16'sh7FFF;
    end else begin
      kmag = (curv < 0) ? -longint'(curv) : longint'(curv);
      ay = (longint'(spd) * spd * kmag + (64'd1 << 19)) >> 20;
      dv = (spd >= last_speed) ? spd - last_speed : last_speed - spd;
      ax = (dv * rate_q4 + 8) >> 4;
      if (ay > 32767) ay = 32767;
      if (ax > 32767) ax = 32767;
      ltr = (ay * gain_q12 + 128) >> 8;
      m.tip = sat16(4096 - longint'(ltr));
      m.slide = sat16(longint'(mu_g_q8) - longint'(isqrt(ax * ax + ay * ay)));
      if (m.tip < run_min_tip) run_min_tip = m.tip;
      if (m.slide < run_min_slide) run_min_slide = m.slide;
      m.metrics_ok = 1'b1;
    end
    last_speed = spd;
    run_open = 1'b1;
    m.min_tip = run_min_tip;
    m.min_slide = run_min_slide;
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Send one sample beat, with an optional random gap before it.
  task automatic send_sample(logic [15:0] spd, logic signed [15:0] curv, logic first);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    speed_i <= spd;
    curvature_i <= curv;
    start_req_i <= first;
    do @(posedge clk_i); while (in_stall);
    pending_margins.push_back(predict_margins(spd, curv, first));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_margins.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      RegLtrGain:    gain_q12 = val;
      RegSlideLimit: mu_g_q8 = val[14:0];
      RegInvPeriod:  rate_q4 = val;
      default: ;
    endcase
  endtask

  // Receiver stall: random bursts, or a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_rx > 0) begin
      out_stall <= 1'b1;
      hold_rx <= hold_rx - 1;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap <= rx_gap - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      rx_gap <= $urandom_range(0, 4);
    end else
      out_stall <= 1'b0;
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    margins_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_margins.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = pending_margins.pop_front();
        if (tip_margin_o !== want.tip) report_mismatch("tip", tip_margin_o, want.tip);
        if (slide_margin_o !== want.slide)
          report_mismatch("slide", slide_margin_o, want.slide);
        if (min_tip_margin_o !== want.min_tip)
          report_mismatch("min_tip", min_tip_margin_o, want.min_tip);
        if (min_slide_margin_o !== want.min_slide)
          report_mismatch("min_slide", min_slide_margin_o, want.min_slide);
        if (metrics_valid_o !== want.metrics_ok)
          report_mismatch("metrics_valid", metrics_valid_o, want.metrics_ok);
      end
    end
  end

  // Field extremes, run restarts and the first sample after reset.
  task automatic test_directed();
    send_sample(16'd1000, 16'sd100, 1'b0);
    send_sample(16'hFFFF, 16'sh7FFF, 1'b0);
    send_sample(16'd0, -16'sh8000, 1'b0);
    send_sample(16'hFFFF, -16'sh8000, 1'b0);
    send_sample(16'd0, 16'sd0, 1'b0);
    send_sample(16'd2560, 16'sd4096, 1'b1);
    send_sample(16'd2600, -16'sd4096, 1'b0);
    send_sample(16'd2600, 16'sd0, 1'b0);
    send_sample(16'd100, 16'sd1, 1'b0);
    send_sample(16'h8000, -16'sd1, 1'b0);
    send_sample(16'h5555, 16'sh2AAA, 1'b1);
    send_sample(16'hAAAA, -16'sh2AAB, 1'b0);
    wait_drained();
  endtask

  // Register extremes, including zero gain, zero rate and a bad index.
  task automatic test_registers();
    logic [15:0] gains[4] = '{16'd0, 16'hFFFF, 16'd381, 16'd4096};
    logic [15:0] mus[4] = '{16'd0, 16'h7FFF, 16'hFFFF, 16'd1758};
    logic [15:0] rates[4] = '{16'd0, 16'hFFFF, 16'd640, 16'd16};
    for (int s = 0; s < 4; s++) begin
      write_reg(RegLtrGain, gains[s]);
      write_reg(RegSlideLimit, mus[s]);
      write_reg(RegInvPeriod, rates[s]);
      write_reg(RegNone, 16'h1234);
      send_sample(16'($urandom), 16'($urandom), 1'b1);
      for (int i = 0; i < 40; i++)
        send_sample(16'($urandom), 16'($urandom), $urandom_range(0, 15) == 0);
      wait_drained();
    end
  endtask

  // Realistic runs of slowly varying speed, with noise samples mixed in.
  task automatic test_random_runs(int n, bit idle);
    logic [15:0] spd;
    tx_idle_en = idle;
    rx_idle_en = idle;
    spd = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) spd = 16'($urandom);
      else spd = spd + 16'($urandom_range(0, 512)) - 16'd256;
      send_sample(spd,
                  16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000) - 1000),
                  $urandom_range(0, 30) == 0);
    end
    wait_drained();
  endtask

  // Long receiver hold-off while samples keep coming, then a full drain.
  task automatic test_backpressure();
    hold_rx = 600;
    for (int i = 0; i < 20; i++) send_sample(16'($urandom), 16'($urandom), 1'b0);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_registers();
    write_reg(RegLtrGain, 16'd381);
    write_reg(RegSlideLimit, 16'd1758);
    write_reg(RegInvPeriod, 16'd640);
    test_backpressure();
    test_random_runs(700, 1'b1);
    write_reg(RegLtrGain, 16'($urandom));
    write_reg(RegSlideLimit, 16'($urandom_range(0, 32767)));
    write_reg(RegInvPeriod, 16'($urandom));
    test_random_runs(400, 1'b0);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
